// File: sv/mpfla_pkg.sv
`default_nettype none
package mpfla_pkg;

  localparam int NUM_POOLS     = 4;
  localparam int POOL_W        = 2;
  localparam int MAX_SLOTS     = 256;
  localparam int SLOT_W        = 9;
  localparam int IDX_W         = 8;
  localparam int OUTSIDE_WIDTH = 16;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int MEM_ADDR_W    = POOL_W + IDX_W;
  localparam int MEM_DEPTH     = NUM_POOLS * MAX_SLOTS;

  localparam logic [SLOT_W-1:0]        SLOTS_MAX   = SLOT_W'(MAX_SLOTS);
  localparam logic [SLOT_W-1:0]        NO_LINK     = SLOT_W'(MAX_SLOTS);
  localparam logic [OUTSIDE_WIDTH-1:0] OUTSIDE_MAX = '1;
  localparam logic [CFG_DATA_W-1:0]    SLOTS_RESET = CFG_DATA_W'(256);

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DISABLED  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DOUBLE    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_OUTSIDE   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NO_CHANGE = 3'd5;

  // slot memory word: taken flag above the free-list link
  typedef struct packed {
    logic              taken;
    logic [SLOT_W-1:0] link;
  } slot_word_t;

endpackage
`default_nettype wire

// File: sv/mpfla_if.sv
`default_nettype none
interface mpfla_req_if
  import mpfla_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POOL_W-1:0] pool;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, mode, pool, slot, input ready);
  modport sink   (input valid, mode, pool, slot, output ready);
endinterface

interface mpfla_rsp_if
  import mpfla_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [IDX_W-1:0]         granted_slot;
  logic [SLOT_W-1:0]        in_use;
  logic [SLOT_W-1:0]        peak_in_use;
  logic [OUTSIDE_WIDTH-1:0] overflow_count;
  logic                     overflow_seen;

  modport source (output valid, status, granted_slot, in_use, peak_in_use,
                  overflow_count, overflow_seen, input ready);
  modport sink   (input valid, status, granted_slot, in_use, peak_in_use,
                  overflow_count, overflow_seen, output ready);
endinterface
`default_nettype wire

// File: sv/multi_pool_free_list_allocator_top.sv
`default_nettype none
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   mode, pool, slot
// rsp       out        valid/ready   status, granted_slot, in_use, peak_in_use,
//                                    overflow_count, overflow_seen
// cfg       in         cfg_wr_en     cfg_index, cfg_data (slots per pool)
//
// Each transaction reads the slot memory at the accept edge and completes the
// single-port read-modify-write in the execute state, so a new request is only
// accepted once the previous one has left the execute state.
// rst is synchronous; pool state and slot registers reset, the slot memory
// is not cleared (entries are only read after their pool has written them).
// A stalled rsp holds the execute state until the output register frees up.
module multi_pool_free_list_allocator_top
  import mpfla_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  mpfla_req_if.sink                  req,
  mpfla_rsp_if.source                rsp,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  logic [CFG_DATA_W-1:0]    slots_reg     [NUM_POOLS];
  logic [SLOT_W-1:0]        freed_head    [NUM_POOLS];
  logic [SLOT_W-1:0]        fresh_next    [NUM_POOLS];
  logic [SLOT_W-1:0]        use_count     [NUM_POOLS];
  logic [SLOT_W-1:0]        peak_count    [NUM_POOLS];
  logic [OUTSIDE_WIDTH-1:0] outside_count [NUM_POOLS];
  logic                     overflow_flag [NUM_POOLS];
  logic                     pool_on       [NUM_POOLS];

  logic [MODE_W-1:0] cur_mode;
  logic [POOL_W-1:0] cur_pool;
  logic [SLOT_W-1:0] cur_slot;

  slot_word_t slot_mem [MEM_DEPTH];
  slot_word_t rd_word;
  slot_word_t wr_word;
  logic [MEM_ADDR_W-1:0] rd_addr;
  logic [MEM_ADDR_W-1:0] wr_addr;
  logic                  mem_we;

  logic accept;
  logic exec_go;

  logic [SLOT_W-1:0]        size;
  logic [SLOT_W-1:0]        head_next;
  logic [SLOT_W-1:0]        fresh_nxt;
  logic [SLOT_W-1:0]        use_next;
  logic [SLOT_W-1:0]        peak_next;
  logic [OUTSIDE_WIDTH-1:0] outside_next;
  logic                     flag_next;
  logic                     on_next;
  logic                     do_init;
  logic [STATUS_W-1:0]      status_next;
  logic [IDX_W-1:0]         granted_next;
  logic                     have_freed;
  logic                     have_fresh;
  logic [IDX_W-1:0]         grant_idx;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_go   = (state == ST_EXEC) && (!rsp.valid || rsp.ready);

  // alloc reads the link at the free-list head, free reads the released slot
  assign rd_addr = {req.pool, (req.mode == MODE_ALLOC) ?
                    freed_head[req.pool][IDX_W-1:0] : req.slot[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_word;
    end
    if (accept) begin
      rd_word <= slot_mem[rd_addr];
    end
  end

  always_comb begin
    size         = (slots_reg[cur_pool] > SLOTS_MAX) ? SLOTS_MAX : slots_reg[cur_pool];
    head_next    = freed_head[cur_pool];
    fresh_nxt    = fresh_next[cur_pool];
    use_next     = use_count[cur_pool];
    peak_next    = peak_count[cur_pool];
    outside_next = outside_count[cur_pool];
    flag_next    = overflow_flag[cur_pool];
    on_next      = pool_on[cur_pool];
    do_init      = 1'b0;
    status_next  = STS_OK;
    granted_next = '0;
    mem_we       = 1'b0;
    wr_addr      = {cur_pool, cur_slot[IDX_W-1:0]};
    wr_word      = '0;
    have_freed   = (freed_head[cur_pool] < SLOTS_MAX);
    have_fresh   = (fresh_next[cur_pool] < size);
    grant_idx    = have_freed ? freed_head[cur_pool][IDX_W-1:0]
                              : fresh_next[cur_pool][IDX_W-1:0];
    case (cur_mode)
      MODE_ALLOC: begin
        if (!pool_on[cur_pool]) begin
          status_next = STS_DISABLED;
        end else if (use_count[cur_pool] >= size || (!have_freed && !have_fresh)) begin
          status_next = STS_OVERFLOW;
          flag_next   = 1'b1;
          if (outside_count[cur_pool] != OUTSIDE_MAX) begin
            outside_next = outside_count[cur_pool] + 1'b1;
          end
        end else begin
          if (have_freed) begin
            head_next    = rd_word.link;
            wr_word.link = rd_word.link;
          end else begin
            fresh_nxt = fresh_next[cur_pool] + 1'b1;
          end
          mem_we        = exec_go;
          wr_addr       = {cur_pool, grant_idx};
          wr_word.taken = 1'b1;
          use_next      = use_count[cur_pool] + 1'b1;
          if (use_next > peak_count[cur_pool]) begin
            peak_next = use_next;
          end
          granted_next = grant_idx;
        end
      end
      MODE_FREE: begin
        if (!pool_on[cur_pool]) begin
          status_next = STS_DISABLED;
        end else if (cur_slot >= size) begin
          status_next = STS_OUTSIDE;
          if (outside_count[cur_pool] != '0) begin
            outside_next = outside_count[cur_pool] - 1'b1;
          end
        end else if (cur_slot >= fresh_next[cur_pool] || !rd_word.taken) begin
          status_next = STS_DOUBLE;
        end else begin
          // push onto the free list: link to the old head, clear taken
          mem_we        = exec_go;
          wr_word.taken = 1'b0;
          wr_word.link  = freed_head[cur_pool];
          head_next     = cur_slot;
          if (use_count[cur_pool] != '0) begin
            use_next = use_count[cur_pool] - 1'b1;
          end
        end
      end
      MODE_ENABLE: begin
        if (pool_on[cur_pool]) begin
          status_next = STS_NO_CHANGE;
        end else begin
          do_init = 1'b1;
        end
      end
      MODE_DISABLE: begin
        if (!pool_on[cur_pool]) begin
          status_next = STS_NO_CHANGE;
        end else begin
          on_next = 1'b0;
        end
      end
      default: begin
        status_next = STS_NO_CHANGE;
      end
    endcase
    if (do_init) begin
      head_next    = NO_LINK;
      fresh_nxt    = '0;
      use_next     = '0;
      peak_next    = '0;
      outside_next = '0;
      flag_next    = 1'b0;
      on_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        slots_reg[i]     <= SLOTS_RESET;
        freed_head[i]    <= NO_LINK;
        fresh_next[i]    <= '0;
        use_count[i]     <= '0;
        peak_count[i]    <= '0;
        outside_count[i] <= '0;
        overflow_flag[i] <= 1'b0;
        pool_on[i]       <= 1'b1;
      end
    end else begin
      if (cfg_wr_en) begin
        slots_reg[cfg_index] <= cfg_data;
      end
      // drop valid on handoff unless a new response replaces it
      if (rsp.valid && rsp.ready && !exec_go) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state                   <= ST_IDLE;
            rsp.valid               <= 1'b1;
            freed_head[cur_pool]    <= head_next;
            fresh_next[cur_pool]    <= fresh_nxt;
            use_count[cur_pool]     <= use_next;
            peak_count[cur_pool]    <= peak_next;
            outside_count[cur_pool] <= outside_next;
            overflow_flag[cur_pool] <= flag_next;
            pool_on[cur_pool]       <= on_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode <= req.mode;
      cur_pool <= req.pool;
      cur_slot <= req.slot;
    end
    if (exec_go) begin
      rsp.status         <= status_next;
      rsp.granted_slot   <= granted_next;
      rsp.in_use         <= use_next;
      rsp.peak_in_use    <= peak_next;
      rsp.overflow_count <= outside_next;
      rsp.overflow_seen  <= flag_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted request did not enter execute cycle");

  a_rsp_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_EXEC)
    else $error("response raised without an execute cycle");

  a_peak_covers_use: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.in_use <= rsp.peak_in_use)
    else $error("in-use count above peak");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != STS_OK |-> rsp.granted_slot == '0)
    else $error("slot granted on a failed request");

endmodule
`default_nettype wire

// File: test/pool_alloc_checker.sv
module pool_alloc_checker
  import mpfla_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  mpfla_req_if                       req,
  mpfla_rsp_if                       rsp,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [IDX_W-1:0]         granted_slot;
    logic [SLOT_W-1:0]        in_use;
    logic [SLOT_W-1:0]        peak_in_use;
    logic [OUTSIDE_WIDTH-1:0] overflow_count;
    logic                     overflow_seen;
  } alloc_result_t;

  // per-pool free-list shadow
  logic [SLOT_W-1:0]        link_mem     [NUM_POOLS][MAX_SLOTS];
  logic                     taken_mem    [NUM_POOLS][MAX_SLOTS];
  logic [SLOT_W-1:0]        free_top     [NUM_POOLS];
  logic [SLOT_W-1:0]        fresh_idx    [NUM_POOLS];
  logic [SLOT_W-1:0]        used_cnt     [NUM_POOLS];
  logic [SLOT_W-1:0]        peak_cnt     [NUM_POOLS];
  logic [OUTSIDE_WIDTH-1:0] outside_cnt  [NUM_POOLS];
  logic                     ovf_flag     [NUM_POOLS];
  logic                     pool_enabled [NUM_POOLS];
  logic [CFG_DATA_W-1:0]    slot_regs    [NUM_POOLS];

  alloc_result_t expected_q [$];
  int            mismatches = 0;

  function automatic void init_pool(int p);
    free_top[p]     = NO_LINK;
    fresh_idx[p]    = '0;
    used_cnt[p]     = '0;
    peak_cnt[p]     = '0;
    outside_cnt[p]  = '0;
    ovf_flag[p]     = 1'b0;
    pool_enabled[p] = 1'b1;
  endfunction

  function automatic alloc_result_t predict_request(logic [MODE_W-1:0] mode,
                                                    logic [POOL_W-1:0] p,
                                                    logic [SLOT_W-1:0] slot);
    alloc_result_t     res;
    logic [SLOT_W-1:0] size;
    logic [SLOT_W-1:0] pick;
    logic              have_freed;
    logic              have_fresh;
    res        = '0;
    res.status = STS_OK;
    size       = (slot_regs[p] > SLOTS_MAX) ? SLOTS_MAX : slot_regs[p];
    case (mode)
      MODE_ALLOC: begin
        if (!pool_enabled[p]) begin
          res.status = STS_DISABLED;
        end else begin
          have_freed = free_top[p] < SLOTS_MAX;
          have_fresh = fresh_idx[p] < size;
          if (used_cnt[p] >= size || (!have_freed && !have_fresh)) begin
            ovf_flag[p] = 1'b1;
            if (outside_cnt[p] != OUTSIDE_MAX) outside_cnt[p]++;
            res.status = STS_OVERFLOW;
          end else begin
            // released slots go first, last released first
            if (have_freed) begin
              pick        = free_top[p];
              free_top[p] = link_mem[p][pick[IDX_W-1:0]];
            end else begin
              pick = fresh_idx[p];
              fresh_idx[p]++;
            end
            taken_mem[p][pick[IDX_W-1:0]] = 1'b1;
            used_cnt[p]++;
            if (used_cnt[p] > peak_cnt[p]) peak_cnt[p] = used_cnt[p];
            res.granted_slot = pick[IDX_W-1:0];
          end
        end
      end
      MODE_FREE: begin
        if (!pool_enabled[p]) begin
          res.status = STS_DISABLED;
        end else if (slot >= size) begin
          if (outside_cnt[p] != '0) outside_cnt[p]--;
          res.status = STS_OUTSIDE;
        end else if (slot >= fresh_idx[p] || !taken_mem[p][slot[IDX_W-1:0]]) begin
          res.status = STS_DOUBLE;
        end else begin
          taken_mem[p][slot[IDX_W-1:0]] = 1'b0;
          link_mem[p][slot[IDX_W-1:0]]  = free_top[p];
          free_top[p]                   = slot;
          if (used_cnt[p] != '0) used_cnt[p]--;
        end
      end
      MODE_ENABLE: begin
        if (pool_enabled[p]) res.status = STS_NO_CHANGE;
        else init_pool(p);
      end
      default: begin
        if (!pool_enabled[p]) res.status = STS_NO_CHANGE;
        else pool_enabled[p] = 1'b0;
      end
    endcase
    res.in_use         = used_cnt[p];
    res.peak_in_use    = peak_cnt[p];
    res.overflow_count = outside_cnt[p];
    res.overflow_seen  = ovf_flag[p];
    return res;
  endfunction

  function automatic int field_diff(string name, longint exp_v, longint act_v);
    if (exp_v == act_v) return 0;
    $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        init_pool(p);
        slot_regs[p] = SLOTS_RESET;
      end
      expected_q.delete();
    end else begin
      if (cfg_wr_en) slot_regs[cfg_index] = cfg_data;
      // retire the response first: it always belongs to an older transaction
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("response with no transaction outstanding, status %0d", rsp.status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_diff("status", want.status, rsp.status);
          mismatches += field_diff("granted_slot", want.granted_slot, rsp.granted_slot);
          mismatches += field_diff("in_use", want.in_use, rsp.in_use);
          mismatches += field_diff("peak_in_use", want.peak_in_use, rsp.peak_in_use);
          mismatches += field_diff("overflow_count", want.overflow_count,
                                   rsp.overflow_count);
          mismatches += field_diff("overflow_seen", want.overflow_seen, rsp.overflow_seen);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(predict_request(req.mode, req.pool, req.slot));
    end
    fail_count  <= mismatches;
    outstanding <= expected_q.size();
  end

endmodule

// File: test/testbench.sv
module testbench
  import mpfla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PHASES = 8;
  localparam int FILL_PHASE  = 3;
  localparam int PAUSE_PHASE = 5;
  localparam int STEADY_PHASE = 6;
  localparam int FILL_ITEMS  = 400;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_DIRECTED = 25;

  localparam logic [CFG_IDX_W-1:0] SLOTS_REG [NUM_POOLS] = '{2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POOL_W-1:0] pool;
    logic [SLOT_W-1:0] slot;
  } req_item_t;

  // pool sizes for this part: 1, 256, 2, 3
  localparam req_item_t DIRECTED [NUM_DIRECTED] = '{
    '{MODE_ALLOC,   2'd0, 9'd0},   '{MODE_ALLOC,   2'd0, 9'd0},
    '{MODE_ALLOC,   2'd0, 9'd0},   '{MODE_FREE,    2'd0, 9'd1},
    '{MODE_FREE,    2'd0, 9'd256}, '{MODE_FREE,    2'd0, 9'd256},
    '{MODE_FREE,    2'd0, 9'd0},   '{MODE_FREE,    2'd0, 9'd0},
    '{MODE_ALLOC,   2'd0, 9'd0},   '{MODE_FREE,    2'd2, 9'd1},
    '{MODE_ALLOC,   2'd1, 9'd0},   '{MODE_ALLOC,   2'd1, 9'd0},
    '{MODE_ALLOC,   2'd1, 9'd0},   '{MODE_FREE,    2'd1, 9'd1},
    '{MODE_FREE,    2'd1, 9'd2},   '{MODE_ALLOC,   2'd1, 9'd0},
    '{MODE_ALLOC,   2'd1, 9'd0},   '{MODE_FREE,    2'd1, 9'd255},
    '{MODE_DISABLE, 2'd3, 9'd0},   '{MODE_DISABLE, 2'd3, 9'd0},
    '{MODE_ALLOC,   2'd3, 9'd0},   '{MODE_FREE,    2'd3, 9'd0},
    '{MODE_ENABLE,  2'd3, 9'd0},   '{MODE_ENABLE,  2'd3, 9'd0},
    '{MODE_DISABLE, 2'd0, 9'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    outstanding;

  mpfla_req_if req_ch ();
  mpfla_rsp_if rsp_ch ();

  multi_pool_free_list_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pool_alloc_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5ns clk = ~clk;

  logic [CFG_DATA_W-1:0] cur_size [NUM_POOLS];
  logic [SLOT_W-1:0]     held_slots [NUM_POOLS][$];
  req_item_t             issued_q [$];
  logic [15:0]           stall_mask;
  logic [3:0]            stall_phase = '0;
  logic [POOL_W-1:0]     hot_pool;
  int                    idle_cycles;
  int                    n_requests = 0;
  int                    n_responses = 0;
  int                    status_seen [8] = '{default: 0};

  // receiver: ready follows a rotating per-phase mask
  always @(posedge clk) begin
    stall_phase  <= stall_phase + 4'd1;
    rsp_ch.ready <= stall_mask[stall_phase];
  end

  // track granted slots so frees mostly hit live slots; also the watchdog
  always @(posedge clk) begin
    req_item_t sent;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready && issued_q.size() != 0) begin
        sent = issued_q.pop_front();
        n_responses++;
        status_seen[rsp_ch.status]++;
        if (sent.mode == MODE_ALLOC && rsp_ch.status == STS_OK)
          held_slots[sent.pool].push_back(SLOT_W'(rsp_ch.granted_slot));
        if (sent.mode == MODE_ENABLE && rsp_ch.status == STS_OK)
          held_slots[sent.pool].delete();
      end
      if (req_ch.valid && req_ch.ready) begin
        issued_q.push_back('{req_ch.mode, req_ch.pool, req_ch.slot});
        n_requests++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(req_item_t it);
    req_ch.valid <= 1'b1;
    req_ch.mode  <= it.mode;
    req_ch.pool  <= it.pool;
    req_ch.slot  <= it.slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes();
    for (int q = 0; q < NUM_POOLS; q++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= SLOTS_REG[q];
      cfg_data  <= cur_size[q];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size(int k, int q);
    int r;
    r = $urandom_range(0, 99);
    if (k == FILL_PHASE && q == 0) return SLOTS_MAX;
    if (k == 1) return (q % 2 == 0) ? CFG_DATA_W'(1) : SLOTS_MAX;
    if (r < 15) return CFG_DATA_W'(1);
    if (r < 30) return SLOTS_MAX;
    return CFG_DATA_W'($urandom_range(2, 12));
  endfunction

  function automatic req_item_t random_item(bit fill);
    req_item_t it;
    int        r;
    int        k;
    r       = $urandom_range(0, 99);
    it.slot = SLOT_W'($urandom_range(0, MAX_SLOTS));
    if (fill) begin
      it.pool = ($urandom_range(0, 9) != 0) ? POOL_W'(0) : POOL_W'($urandom_range(0, 3));
      it.mode = (r < 95) ? MODE_ALLOC : MODE_FREE;
    end else begin
      it.pool = ($urandom_range(0, 99) < 40) ? hot_pool : POOL_W'($urandom_range(0, 3));
      if (r < 45) it.mode = MODE_ALLOC;
      else if (r < 85) it.mode = MODE_FREE;
      else if (r < 92) it.mode = MODE_ENABLE;
      else it.mode = MODE_DISABLE;
    end
    if (it.mode == MODE_FREE) begin
      r = $urandom_range(0, 99);
      if (held_slots[it.pool].size() != 0 && r < 75) begin
        k       = $urandom_range(0, held_slots[it.pool].size() - 1);
        it.slot = held_slots[it.pool][k];
        held_slots[it.pool].delete(k);
      end else if (r < 85) begin
        it.slot = SLOT_W'($urandom_range(0, cur_size[it.pool]));
      end else if (r < 92) begin
        it.slot = SLOTS_MAX;
      end
    end
    return it;
  endfunction

  task automatic run_phase(int n_items, bit fill, bit pause_mid, int gap_max);
    int sent;
    int burst;
    int gap;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        send_item(random_item(fill));
        sent++;
      end
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (pause_mid && !paused && sent >= n_items / 2) begin
        // hold off until everything in flight has come back
        req_ch.valid <= 1'b0;
        paused = 1'b1;
        wait_drained();
      end else if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    req_item_t wake;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= MODE_ALLOC;
    req_ch.pool  <= '0;
    req_ch.slot  <= '0;
    stall_mask   <= 16'hFFFF;
    hot_pool     = '0;
    wake         = '{MODE_ENABLE, 2'd0, 9'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    cur_size = '{CFG_DATA_W'(1), SLOTS_MAX, CFG_DATA_W'(2), CFG_DATA_W'(3)};
    write_sizes();
    stall_mask <= 16'($urandom()) | 16'h0001;
    for (int i = 0; i < NUM_DIRECTED; i++) send_item(DIRECTED[i]);
    req_ch.valid <= 1'b0;
    wait_drained();

    for (int k = 0; k < RAND_PHASES; k++) begin
      for (int q = 0; q < NUM_POOLS; q++) cur_size[q] = pick_size(k, q);
      write_sizes();
      if (k == STEADY_PHASE || $urandom_range(0, 3) == 0) stall_mask <= 16'hFFFF;
      else stall_mask <= 16'($urandom()) | 16'h0001;
      hot_pool = POOL_W'($urandom_range(0, 3));
      if (k == FILL_PHASE) begin
        // bring pool zero back up, then drive it past its full size
        send_item(wake);
        run_phase(FILL_ITEMS, 1'b1, 1'b0, 6);
      end else begin
        run_phase(PHASE_ITEMS, 1'b0, k == PAUSE_PHASE, (k == STEADY_PHASE) ? 0 : 6);
      end
      wait_drained();
    end

    $display("Summary: %0d requests, %0d responses over %0d pool-size settings (1..256)",
             n_requests, n_responses, RAND_PHASES + 1);
    $display("Summary: ok %0d, overflow %0d, disabled %0d, double free %0d, outside %0d, %s %0d",
             status_seen[STS_OK], status_seen[STS_OVERFLOW], status_seen[STS_DISABLED],
             status_seen[STS_DOUBLE], status_seen[STS_OUTSIDE], "no change",
             status_seen[STS_NO_CHANGE]);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: multi_pool_free_list_allocator_top.f
sv/mpfla_pkg.sv
sv/mpfla_if.sv
sv/multi_pool_free_list_allocator_top.sv
test/pool_alloc_checker.sv
test/testbench.sv
